[sv/cls_pkg.sv]
`timescale 1ns / 1ps

package cls_pkg;

  // Field widths of the request and result beats.
  localparam int REQ_W  = 2;
  localparam int ID_W   = 10;
  localparam int XY_W   = 5;
  localparam int AC_W   = 6;
  localparam int STAT_W = 2;

  // Per-cell fill count, enough for up to seven slots.
  localparam int CNT_W  = 3;

  // The 3x3 block around a particle, indexed row-major from 0 to 8.
  localparam int NCELL  = 9;
  localparam int K_W    = 4;

  // Running result count and the cap on ids emitted by one query.
  localparam int N_W     = 6;
  localparam int MAX_OUT = 54;

  localparam logic [AC_W-1:0] AC_RESET = AC_W'(25);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take_item;
    logic              clear_all;
    logic              ins_rd;
    logic              ins_wr;
    logic              pc_rd;
    logic              pc_take;
    logic              row_rd;
    logic              row_take;
    logic              row_skip;
    logic              emit_init;
    logic              slot_rd;
    logic              out_load_slot;
    logic              out_load_rsp;
    logic              rsp_set;
    logic [STAT_W-1:0] rsp_code;
  } cls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ins_ok;
    logic             pid_ok;
    logic             cell_full;
    logic             row_ok;
    logic             row_last;
    logic             total_zero;
    logic             out_free;
    logic             last_pend;
  } cls_sts_t;

endpackage

[sv/cls_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module cls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/cls_ctrl.sv]
`timescale 1ns / 1ps

module cls_ctrl
  import cls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cls_sts_t sts,
  output cls_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISP     = 10'b00_0000_0010,
    S_INS_WR   = 10'b00_0000_0100,
    S_QRY_PC   = 10'b00_0000_1000,
    S_ROW      = 10'b00_0001_0000,
    S_ROW_TK   = 10'b00_0010_0000,
    S_EMIT_CHK = 10'b00_0100_0000,
    S_EMIT     = 10'b00_1000_0000,
    S_EMIT_LD  = 10'b01_0000_0000,
    S_RSP      = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next-state and command decode.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.rsp_set   = 1'b1;
            cmd.rsp_code  = ST_OK;
            state_nxt     = S_RSP;
          end
          REQ_INSERT: begin
            if (sts.ins_ok) begin
              cmd.ins_rd = 1'b1;
              state_nxt  = S_INS_WR;
            end else begin
              cmd.rsp_set  = 1'b1;
              cmd.rsp_code = ST_DROP;
              state_nxt    = S_RSP;
            end
          end
          REQ_QUERY: begin
            if (sts.pid_ok) begin
              cmd.pc_rd = 1'b1;
              state_nxt = S_QRY_PC;
            end else begin
              cmd.rsp_set  = 1'b1;
              cmd.rsp_code = ST_EMPTY;
              state_nxt    = S_RSP;
            end
          end
          default: begin
            // Unused request code: no result.
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_INS_WR: begin
        cmd.rsp_set = 1'b1;
        if (sts.cell_full) begin
          cmd.rsp_code = ST_DROP;
        end else begin
          cmd.ins_wr   = 1'b1;
          cmd.rsp_code = ST_OK;
        end
        state_nxt = S_RSP;
      end
      S_QRY_PC: begin
        cmd.pc_take = 1'b1;
        state_nxt   = S_ROW;
      end
      S_ROW: begin
        if (sts.row_ok) begin
          cmd.row_rd = 1'b1;
          state_nxt  = S_ROW_TK;
        end else begin
          cmd.row_skip = 1'b1;
          state_nxt    = sts.row_last ? S_EMIT_CHK : S_ROW;
        end
      end
      S_ROW_TK: begin
        cmd.row_take = 1'b1;
        state_nxt    = sts.row_last ? S_EMIT_CHK : S_ROW;
      end
      S_EMIT_CHK: begin
        if (sts.total_zero) begin
          cmd.rsp_set  = 1'b1;
          cmd.rsp_code = ST_EMPTY;
          state_nxt    = S_RSP;
        end else begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.out_load_slot = 1'b1;
        state_nxt         = sts.last_pend ? S_IDLE : S_EMIT;
      end
      S_RSP: begin
        if (sts.out_free) begin
          cmd.out_load_rsp = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/cls_dp.sv]
`timescale 1ns / 1ps

module cls_dp
  import cls_pkg::*;
#(
  parameter int GRID        = 32,
  parameter int SLOTS       = 6,
  parameter int N_PARTICLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ID_W-1:0]   in_particle_id,
  input  logic [XY_W-1:0]   in_cell_x,
  input  logic [XY_W-1:0]   in_cell_y,
  input  logic              cfg_valid,
  input  logic [AC_W-1:0]   cfg_active_cells,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_neighbour_id,
  output logic              out_last,
  input  cls_cmd_t          cmd,
  output cls_sts_t          sts
);

  localparam int CW     = $clog2(GRID);
  localparam int LW     = (CW + 1 > AC_W) ? CW + 1 : AC_W;
  localparam int SDEPTH = GRID * GRID * SLOTS;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int PW     = $clog2(N_PARTICLES);
  localparam int ROW_W  = GRID * CNT_W;

  // Slot-memory base address of cell (x, y).
  function automatic logic [SA_W-1:0] slot_base(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
    logic [SA_W-1:0] cell_idx;
    cell_idx = SA_W'(x) * SA_W'(GRID) + SA_W'(y);
    return SA_W'(cell_idx * SA_W'(SLOTS));
  endfunction

  // First block position at or after start that holds any id.
  function automatic logic [K_W-1:0] next_nz(input logic [K_W:0]     start,
                                             input logic [NCELL-1:0] nz);
    logic [K_W-1:0] pick;
    pick = K_W'(NCELL - 1);
    for (int j = NCELL - 1; j >= 0; j--) begin
      if (nz[j] && (K_W + 1)'(j) >= start) begin
        pick = K_W'(j);
      end
    end
    return pick;
  endfunction

  // Configuration register and the usable cell limit.
  logic [AC_W-1:0] active_r;
  logic [LW-1:0]   lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= AC_RESET;
    end else if (cfg_valid) begin
      active_r <= cfg_active_cells;
    end
  end

  assign lim = (LW'(active_r) < LW'(GRID)) ? LW'(active_r) : LW'(GRID);

  // Latched request.
  logic [REQ_W-1:0] req_r;
  logic [ID_W-1:0]  pid_r;
  logic [XY_W-1:0]  x_r;
  logic [XY_W-1:0]  y_r;
  logic [CW-1:0]    xi;
  logic [CW-1:0]    yi;
  logic             pid_ok;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      req_r <= in_req_type;
      pid_r <= in_particle_id;
      x_r   <= in_cell_x;
      y_r   <= in_cell_y;
    end
  end

  assign xi     = CW'(x_r);
  assign yi     = CW'(y_r);
  assign pid_ok = 32'(pid_r) < N_PARTICLES;

  // Count memory: one row of GRID fill counts per x, with a valid bit per row
  // so that a clear empties every cell at once.
  logic [GRID-1:0]  rowv_r;
  logic             rv_q_r;
  logic [CW-1:0]    cnt_raddr;
  logic             cnt_re;
  logic [ROW_W-1:0] cnt_rdata;
  logic [ROW_W-1:0] new_row;
  logic [CNT_W-1:0] row_cnt [GRID];
  logic [CNT_W-1:0] cur_cnt;

  logic [LW-1:0]    row_sum;
  logic [CW-1:0]    row_addr;
  logic [1:0]       ix_r;

  assign cnt_raddr = cmd.ins_rd ? xi : row_addr;
  assign cnt_re    = cmd.ins_rd | cmd.row_rd;

  cls_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GRID)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .waddr (xi),
    .wdata (new_row),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
    end else if (cmd.clear_all) begin
      rowv_r <= '0;
    end else if (cmd.ins_wr) begin
      rowv_r[xi] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      rv_q_r <= rowv_r[cnt_raddr];
    end
  end

  // Unpack the row just read and build the row written back by an insert.
  for (genvar i = 0; i < GRID; i++) begin : g_row
    assign row_cnt[i] = rv_q_r ? cnt_rdata[i*CNT_W +: CNT_W] : '0;
    assign new_row[i*CNT_W +: CNT_W] = (CW'(i) == yi) ? cur_cnt + CNT_W'(1) : row_cnt[i];
  end

  assign cur_cnt = row_cnt[yi];

  // Particle-to-cell memory, holding {x, y}.
  logic [2*CW-1:0] pc_rdata;

  cls_ram #(
    .WIDTH (2 * CW),
    .DEPTH (N_PARTICLES)
  ) u_pc_ram (
    .clk   (clk),
    .we    (cmd.ins_rd),
    .waddr (PW'(pid_r)),
    .wdata ({xi, yi}),
    .re    (cmd.pc_rd),
    .raddr (PW'(pid_r)),
    .rdata (pc_rdata)
  );

  // Slot memory: SLOTS ids per cell in insertion order.
  logic [SA_W-1:0] slot_waddr;
  logic [SA_W-1:0] slot_raddr;
  logic [ID_W-1:0] slot_rdata;

  assign slot_waddr = slot_base(xi, yi) + SA_W'(cur_cnt);

  cls_ram #(
    .WIDTH (ID_W),
    .DEPTH (SDEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .waddr (slot_waddr),
    .wdata (pid_r),
    .re    (cmd.slot_rd),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Query: center cell and the neighbor rows and columns around it.
  logic [CW-1:0]    cx_r;
  logic [CW-1:0]    cy_r;
  logic [LW-1:0]    col_sum [3];
  logic [CW-1:0]    col_idx [3];
  logic [2:0]       col_ok;
  logic [CNT_W-1:0] nc [3];
  logic [SA_W-1:0]  nb [3];

  assign row_sum  = LW'(cx_r) + LW'(ix_r) - LW'(1);
  assign row_addr = CW'(row_sum);

  for (genvar c = 0; c < 3; c++) begin : g_col
    assign col_sum[c] = LW'(cy_r) + LW'(c) - LW'(1);
    assign col_idx[c] = CW'(col_sum[c]);
    assign col_ok[c]  = col_sum[c] < lim;
    always_comb begin
      nc[c] = '0;
      if (cmd.row_take && col_ok[c]) begin
        nc[c] = (row_cnt[col_idx[c]] > CNT_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                       : row_cnt[col_idx[c]];
      end
    end
    assign nb[c] = slot_base(row_addr, col_idx[c]);
  end

  // Block counts and bases, shifted in one row at a time.
  logic [CNT_W-1:0] cnt_r  [NCELL];
  logic [SA_W-1:0]  base_r [NCELL];
  logic [N_W-1:0]   total_r;
  logic [NCELL-1:0] nz;
  logic [N_W-1:0]   cap;

  always_ff @(posedge clk) begin
    if (cmd.pc_take) begin
      cx_r    <= pc_rdata[2*CW-1:CW];
      cy_r    <= pc_rdata[CW-1:0];
      ix_r    <= '0;
      total_r <= '0;
    end else if (cmd.row_take || cmd.row_skip) begin
      for (int k = 0; k < NCELL - 3; k++) begin
        cnt_r[k]  <= cnt_r[k+3];
        base_r[k] <= base_r[k+3];
      end
      for (int c = 0; c < 3; c++) begin
        cnt_r[NCELL-3+c]  <= nc[c];
        base_r[NCELL-3+c] <= nb[c];
      end
      ix_r    <= ix_r + 2'd1;
      total_r <= total_r + N_W'(nc[0]) + N_W'(nc[1]) + N_W'(nc[2]);
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_nz
    assign nz[k] = cnt_r[k] != '0;
  end

  assign cap = (total_r > N_W'(MAX_OUT)) ? N_W'(MAX_OUT) : total_r;

  // Emission walk over (block position, slot).
  logic [K_W-1:0]   k_r;
  logic [CNT_W-1:0] r_r;
  logic [N_W-1:0]   n_r;
  logic             last_pend_r;

  assign slot_raddr = base_r[k_r] + SA_W'(r_r);

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      k_r <= next_nz('0, nz);
      r_r <= '0;
      n_r <= '0;
    end else if (cmd.slot_rd) begin
      last_pend_r <= ((N_W + 1)'(n_r) + (N_W + 1)'(1)) == (N_W + 1)'(cap);
      n_r         <= n_r + N_W'(1);
      if ((CNT_W + 1)'(r_r) + (CNT_W + 1)'(1) < (CNT_W + 1)'(cnt_r[k_r])) begin
        r_r <= r_r + CNT_W'(1);
      end else begin
        k_r <= next_nz((K_W + 1)'(k_r) + (K_W + 1)'(1), nz);
        r_r <= '0;
      end
    end
  end

  // Response status for single-beat results.
  logic [STAT_W-1:0] rsp_status_r;

  always_ff @(posedge clk) begin
    if (cmd.rsp_set) begin
      rsp_status_r <= cmd.rsp_code;
    end
  end

  // Output register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_slot || cmd.out_load_rsp) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_slot) begin
      out_status_r <= ST_OK;
      out_id_r     <= slot_rdata;
      out_last_r   <= last_pend_r;
    end else if (cmd.out_load_rsp) begin
      out_status_r <= rsp_status_r;
      out_id_r     <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_neighbour_id = out_id_r;
  assign out_last         = out_last_r;

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.req        = req_r;
    sts.ins_ok     = pid_ok && (LW'(x_r) < lim) && (LW'(y_r) < lim);
    sts.pid_ok     = pid_ok;
    sts.cell_full  = cur_cnt >= CNT_W'(SLOTS);
    sts.row_ok     = row_sum < lim;
    sts.row_last   = ix_r == 2'd2;
    sts.total_zero = total_r == '0;
    sts.out_free   = !out_valid_r || out_ready;
    sts.last_pend  = last_pend_r;
  end

endmodule

[sv/cell_list_neighbour_search_top.sv]
// Two-dimensional cell-list binning engine. Each beat on the in_ channel is a
// clear, an insert or a query; every clear and insert gives one result beat,
// and a query gives one beat per id found in the 3x3 block around the queried
// particle's cell (row x-1, x, x+1, columns y-1, y, y+1, slots in insertion
// order, at most 54), or a single beat with status 2 when none is found; the
// final beat of each request has out_last set. One request is handled at a
// time. An insert reads the cell's fill count from memory and writes it
// back. A query looks up the particle's cell and reads the up to three rows
// of fill counts, then emits its ids one at a time through the slot memory's
// registered read with one read in flight; a stalled out_ready holds the
// emission. Clears act at once through per-row valid bits, so no clearing
// pass follows reset. active_cells is written on the cfg_ port, which is
// always ready; the user must write it only while no request is in
// progress, as the block itself does not enforce this.
`timescale 1ns / 1ps

module cell_list_neighbour_search_top
  import cls_pkg::*;
#(
  parameter int GRID        = 32,
  parameter int SLOTS       = 6,
  parameter int N_PARTICLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ID_W-1:0]   in_particle_id,
  input  logic [XY_W-1:0]   in_cell_x,
  input  logic [XY_W-1:0]   in_cell_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_neighbour_id,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [AC_W-1:0]   cfg_active_cells
);

  cls_cmd_t cmd;
  cls_sts_t sts;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cls_dp #(
    .GRID        (GRID),
    .SLOTS       (SLOTS),
    .N_PARTICLES (N_PARTICLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_particle_id   (in_particle_id),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .cfg_valid        (cfg_valid),
    .cfg_active_cells (cfg_active_cells),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_neighbour_id (out_neighbour_id),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[sv/cls_checker.sv]
`timescale 1ns / 1ps

module cls_checker
  import cls_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [ID_W-1:0]   out_neighbour_id,
  input logic              out_last
);

  // A stalled result beat holds its payload.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_neighbour_id) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A dropped insert or an empty query is a single closing beat with no id.
  a_non_ok_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_neighbour_id == '0)
    else $error("non-ok result is not a lone final beat with id zero");

  // One request at a time: acceptance leaves the idle state.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Reset empties the output register.
  a_reset_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat pending right after reset");

endmodule

bind cell_list_neighbour_search_top cls_checker u_cls_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_neighbour_id (out_neighbour_id),
  .out_last         (out_last)
);

[tb/cls_search_checker.sv]
`timescale 1ns / 1ps

module cls_search_checker
  import cls_pkg::*;
#(
  parameter int GRID        = 32,
  parameter int SLOTS       = 6,
  parameter int N_PARTICLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ID_W-1:0]   in_particle_id,
  input  logic [XY_W-1:0]   in_cell_x,
  input  logic [XY_W-1:0]   in_cell_y,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic [ID_W-1:0]   out_neighbour_id,
  input  logic              out_last,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [AC_W-1:0]   cfg_active_cells,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic              last;
  } result_beat_t;

  // Result beats still owed by the block, oldest first.
  result_beat_t neighbour_beats_q[$];

  // Shadow copy of the cell lists.
  logic [CNT_W-1:0] cell_fill [GRID*GRID];
  logic [ID_W-1:0]  cell_ids  [GRID*GRID*SLOTS];
  int               home_cell [N_PARTICLES];
  int               cells_in_use;

  // The usable span per axis never exceeds the grid.
  function automatic int clip_span(input logic [AC_W-1:0] v);
    return (int'(v) < GRID) ? int'(v) : GRID;
  endfunction

  function automatic void owe_beat(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] id,
                                   input logic lst);
    result_beat_t b;
    b.status = st;
    b.id     = id;
    b.last   = lst;
    neighbour_beats_q.push_back(b);
  endfunction

  // Apply one request to the shadow cell lists and queue the beats it yields.
  function automatic void bin_and_search(input logic [REQ_W-1:0] rq,
                                         input logic [ID_W-1:0] pid,
                                         input logic [XY_W-1:0] x,
                                         input logic [XY_W-1:0] y);
    int              cell_idx;
    int              cx;
    int              cy;
    logic [ID_W-1:0] found [$];
    case (rq)
      REQ_CLEAR: begin
        foreach (cell_fill[i]) cell_fill[i] = '0;
        owe_beat(ST_OK, '0, 1'b1);
      end
      REQ_INSERT: begin
        if (int'(pid) >= N_PARTICLES || int'(x) >= cells_in_use || int'(y) >= cells_in_use) begin
          owe_beat(ST_DROP, '0, 1'b1);
        end else begin
          cell_idx = int'(x) * GRID + int'(y);
          // The particle's cell is recorded even when its cell is full.
          home_cell[pid] = cell_idx;
          if (int'(cell_fill[cell_idx]) >= SLOTS) begin
            owe_beat(ST_DROP, '0, 1'b1);
          end else begin
            cell_ids[cell_idx*SLOTS + int'(cell_fill[cell_idx])] = pid;
            cell_fill[cell_idx] = cell_fill[cell_idx] + 1'b1;
            owe_beat(ST_OK, '0, 1'b1);
          end
        end
      end
      REQ_QUERY: begin
        if (int'(pid) < N_PARTICLES) begin
          cx = home_cell[pid] / GRID;
          cy = home_cell[pid] % GRID;
          // Walk the 3x3 block row by row, clipping at the edges of the active area.
          for (int ax = cx - 1; ax <= cx + 1; ax++) begin
            for (int ay = cy - 1; ay <= cy + 1; ay++) begin
              if (ax >= 0 && ax < cells_in_use && ay >= 0 && ay < cells_in_use) begin
                cell_idx = ax * GRID + ay;
                for (int r = 0; r < int'(cell_fill[cell_idx]) && found.size() < MAX_OUT;
                     r++) begin
                  found.push_back(cell_ids[cell_idx*SLOTS + r]);
                end
              end
            end
          end
        end
        if (found.size() == 0) begin
          owe_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (found[i]) owe_beat(ST_OK, found[i], i == found.size() - 1);
        end
      end
      default: begin
        // The unused request code yields nothing.
      end
    endcase
  endfunction

  // Track the three channels and compare every result beat with the oldest one owed.
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst_n) begin
      foreach (cell_fill[i]) cell_fill[i] = '0;
      cells_in_use = clip_span(AC_RESET);
      neighbour_beats_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cells_in_use = clip_span(cfg_active_cells);
      end
      if (in_valid && in_ready) begin
        bin_and_search(in_req_type, in_particle_id, in_cell_x, in_cell_y);
      end
      if (out_valid && out_ready) begin
        if (neighbour_beats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: status %0d id %0d last %0d",
                     out_status, out_neighbour_id, out_last);
          end
        end else begin
          want = neighbour_beats_q.pop_front();
          if (out_status !== want.status || out_neighbour_id !== want.id ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected status %0d id %0d last %0d, got %0d %0d %0d",
                       want.status, want.id, want.last,
                       out_status, out_neighbour_id, out_last);
            end
          end
        end
      end
    end
    outstanding = neighbour_beats_q.size();
  end

endmodule

[tb/tb_cell_list_neighbour_search_top.sv]
`timescale 1ns / 1ps

module tb_cell_list_neighbour_search_top;
  import cls_pkg::*;

  localparam int GRID        = 32;
  localparam int SLOTS       = 6;
  localparam int N_PARTICLES = 1024;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Length of the long downstream hold-off and of the quiet time before a register write.
  localparam int LONG_HOLD = 400;
  localparam int SETTLE    = 40;

  // Idle patterns of the two sides.
  localparam int MODE_SLOW_RX = 0;
  localparam int MODE_SLOW_TX = 1;
  localparam int MODE_NO_IDLE = 2;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type      = '0;
  logic [ID_W-1:0]   in_particle_id   = '0;
  logic [XY_W-1:0]   in_cell_x        = '0;
  logic [XY_W-1:0]   in_cell_y        = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_neighbour_id;
  logic              out_last;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [AC_W-1:0]   cfg_active_cells = '0;

  int mismatches;
  int outstanding;

  int   tx_idle_pct = 38;
  int   rx_idle_pct = 74;
  logic hold_tgl    = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  // Cells per axis now in use, and the particles whose cell has been recorded.
  int              span = 25;
  bit              placed [N_PARTICLES];
  logic [ID_W-1:0] placed_q[$];
  int              hot_x;
  int              hot_y;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cell_list_neighbour_search_top #(
    .GRID        (GRID),
    .SLOTS       (SLOTS),
    .N_PARTICLES (N_PARTICLES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_particle_id   (in_particle_id),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_neighbour_id (out_neighbour_id),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_cells (cfg_active_cells)
  );

  cls_search_checker #(
    .GRID        (GRID),
    .SLOTS       (SLOTS),
    .N_PARTICLES (N_PARTICLES)
  ) search_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_particle_id   (in_particle_id),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_neighbour_id (out_neighbour_id),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_cells (cfg_active_cells),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Downstream side: random back-pressure, and a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one request beat and hold it until it is taken; returns at a falling edge.
  task automatic send_request(input logic [REQ_W-1:0] rq, input logic [ID_W-1:0] pid,
                              input logic [XY_W-1:0] x, input logic [XY_W-1:0] y);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rq;
    in_particle_id <= pid;
    in_cell_x      <= x;
    in_cell_y      <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (rq == REQ_INSERT && int'(x) < span && int'(y) < span && !placed[pid]) begin
      placed[pid] = 1'b1;
      placed_q.push_back(pid);
    end
  endtask

  // Stop offering and wait until every owed result beat has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_active_cells(input logic [AC_W-1:0] v);
    drain_results();
    // A request with no result may still be in flight.
    repeat (SETTLE) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_active_cells <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    span = (int'(v) < GRID) ? int'(v) : GRID;
  endtask

  // A coordinate within one cell of c, kept on the grid.
  function automatic logic [XY_W-1:0] near(input int c);
    int t;
    t = c + $urandom_range(2) - 1;
    if (t < 0) t = 0;
    if (t > GRID - 1) t = GRID - 1;
    return XY_W'(t);
  endfunction

  // Mostly inserts crowding a 3x3 patch and queries of placed particles, with some noise.
  task automatic send_random_request(input int cx, input int cy);
    int              pick;
    logic [ID_W-1:0] pid;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_request(REQ_CLEAR, ID_W'($urandom), XY_W'($urandom), XY_W'($urandom));
    end else if (pick < 5) begin
      send_request(REQ_UNUSED, ID_W'($urandom), XY_W'($urandom), XY_W'($urandom));
    end else if (pick < 60 || placed_q.size() == 0) begin
      if ($urandom_range(3) == 0 && placed_q.size() != 0) begin
        pid = placed_q[$urandom_range(placed_q.size() - 1)];
      end else begin
        pid = ID_W'($urandom);
      end
      if ($urandom_range(4) == 0) begin
        send_request(REQ_INSERT, pid, XY_W'($urandom), XY_W'($urandom));
      end else begin
        send_request(REQ_INSERT, pid, near(cx), near(cy));
      end
    end else begin
      pid = placed_q[$urandom_range(placed_q.size() - 1)];
      send_request(REQ_QUERY, pid, XY_W'($urandom), XY_W'($urandom));
    end
  endtask

  task automatic run_phase(input logic [AC_W-1:0] ac, input int beats, input int mode,
                           input bit long_hold, input bit mid_pause);
    int cx;
    int cy;
    write_active_cells(ac);
    case (mode)
      MODE_SLOW_RX: begin
        tx_idle_pct = 38;
        rx_idle_pct = 74;
      end
      MODE_SLOW_TX: begin
        tx_idle_pct = 74;
        rx_idle_pct = 38;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
    // Keep the crowded patch where it was, pulled inside the active area.
    cx = (hot_x < span) ? hot_x : ((span > 0) ? span - 1 : 0);
    cy = (hot_y < span) ? hot_y : ((span > 0) ? span - 1 : 0);
    if (long_hold) hold_tgl <= ~hold_tgl;
    for (int k = 0; k < beats; k++) begin
      if (mid_pause && k == beats / 2) drain_results();
      send_random_request(cx, cy);
    end
  endtask

  initial begin
    hot_x = $urandom_range(2, 1);
    hot_y = $urandom_range(2, 1);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset setting of 25 cells per axis.
    send_request(REQ_CLEAR, 10'd0, 5'd0, 5'd0);
    send_request(REQ_INSERT, 10'd0, 5'd0, 5'd0);
    send_request(REQ_INSERT, 10'd1023, 5'd24, 5'd24);
    send_request(REQ_INSERT, 10'd5, 5'd25, 5'd3);
    send_request(REQ_INSERT, 10'd6, 5'd3, 5'd31);
    for (int i = 10; i < 16; i++) send_request(REQ_INSERT, ID_W'(i), 5'd5, 5'd5);
    // The cell is full now: this one is dropped but its cell is still recorded.
    send_request(REQ_INSERT, 10'd16, 5'd5, 5'd5);
    send_request(REQ_INSERT, 10'd20, 5'd4, 5'd4);
    send_request(REQ_INSERT, 10'd21, 5'd6, 5'd6);
    send_request(REQ_INSERT, 10'd22, 5'd4, 5'd6);
    send_request(REQ_INSERT, 10'd20, 5'd6, 5'd4);
    send_request(REQ_UNUSED, 10'd1023, 5'd31, 5'd31);
    send_request(REQ_QUERY, 10'd16, 5'd0, 5'd0);
    send_request(REQ_QUERY, 10'd0, 5'd0, 5'd0);
    send_request(REQ_QUERY, 10'd1023, 5'd0, 5'd0);
    send_request(REQ_QUERY, 10'd20, 5'd0, 5'd0);
    send_request(REQ_CLEAR, 10'd1023, 5'd31, 5'd31);
    send_request(REQ_QUERY, 10'd0, 5'd0, 5'd0);
    send_request(REQ_INSERT, 10'd0, 5'd0, 5'd0);
    send_request(REQ_QUERY, 10'd0, 5'd0, 5'd0);

    // Random phases over several settings, with each idle pattern in turn.
    run_phase(6'd32, 20, MODE_SLOW_RX, 1'b1, 1'b0);
    run_phase(6'd3,  18, MODE_SLOW_RX, 1'b0, 1'b1);
    run_phase(6'd63, 20, MODE_SLOW_RX, 1'b0, 1'b0);
    run_phase(6'd1,  12, MODE_SLOW_TX, 1'b0, 1'b0);
    run_phase(6'd0,  10, MODE_SLOW_TX, 1'b0, 1'b0);
    run_phase(6'd25, 20, MODE_SLOW_TX, 1'b0, 1'b0);
    run_phase(6'd2,  14, MODE_NO_IDLE, 1'b0, 1'b0);
    run_phase(6'd32, 26, MODE_NO_IDLE, 1'b0, 1'b0);
    run_phase(6'd7,  20, MODE_NO_IDLE, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
